// ----- src/gda_pkg.sv -----
package gda_pkg;

    localparam int DAY_COUNT_BITS_DEF = 16;

    localparam int YEAR_BITS  = 14;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int DIFF_BITS  = 23;
    localparam int CENT_BITS  = 8;
    localparam int YC_BITS    = 7;
    localparam int DOY_BITS   = 9;
    localparam int PROD_BITS  = 27;

    localparam logic [YEAR_BITS-1:0] YEAR_LOW  = 14'd1801;
    localparam logic [YEAR_BITS-1:0] YEAR_HIGH = 14'd9999;
    localparam logic [CENT_BITS-1:0] CENT_LOW  = 8'd18;
    localparam logic [YC_BITS-1:0]   YC_LOW    = 7'd1;
    localparam logic [CENT_BITS-1:0] CENT_HIGH = 8'd99;
    localparam logic [YC_BITS-1:0]   YC_HIGH   = 7'd99;
    localparam logic [YEAR_BITS-1:0] CENTURY   = 14'd100;

    // Multiplying by DIV100_MUL and shifting by DIV100_SHIFT divides any
    // 14-bit year by 100 exactly.
    localparam logic [PROD_BITS-1:0] DIV100_MUL   = 27'd5243;
    localparam int                   DIV100_SHIFT = 19;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_DIFF = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic in_ready;
        logic div;
        logic rem;
        logic check;
        logic year_step;
        logic month_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic check_bad;
        logic year_done;
        logic range_hit;
        logic is_diff;
        logic month_done;
        logic out_free;
    } t_stat;

    function automatic logic is_leap(input logic [CENT_BITS-1:0] cent,
                                     input logic [YC_BITS-1:0] yc);
        is_leap = (yc[1:0] == 2'd0) && ((yc != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic lp);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            4'd2: month_len = lp ? 5'd29 : 5'd28;
            default: month_len = 5'd0;
        endcase
    endfunction

    function automatic logic [DOY_BITS-1:0] month_start(input logic [MONTH_BITS-1:0] m);
        case (m)
            4'd1: month_start = 9'd0;
            4'd2: month_start = 9'd31;
            4'd3: month_start = 9'd59;
            4'd4: month_start = 9'd90;
            4'd5: month_start = 9'd120;
            4'd6: month_start = 9'd151;
            4'd7: month_start = 9'd181;
            4'd8: month_start = 9'd212;
            4'd9: month_start = 9'd243;
            4'd10: month_start = 9'd273;
            4'd11: month_start = 9'd304;
            4'd12: month_start = 9'd334;
            default: month_start = 9'd0;
        endcase
    endfunction

    function automatic logic [DOY_BITS-1:0] year_len(input logic lp);
        year_len = lp ? 9'd366 : 9'd365;
    endfunction

    function automatic logic date_ok(input logic [MONTH_BITS-1:0] m,
                                     input logic [DAY_BITS-1:0] d,
                                     input logic [YEAR_BITS-1:0] y,
                                     input logic lp);
        date_ok = (y >= YEAR_LOW) && (y <= YEAR_HIGH) && (m >= 4'd1) && (m <= 4'd12)
                  && (d >= 5'd1) && (d <= month_len(m, lp));
    endfunction

    function automatic logic [DOY_BITS-1:0] ordinal_day(input logic [MONTH_BITS-1:0] m,
                                                        input logic [DAY_BITS-1:0] d,
                                                        input logic lp);
        ordinal_day = month_start(m) + DOY_BITS'(d) - 9'd1
                      + ((lp && (m > MONTH_FEB)) ? 9'd1 : 9'd0);
    endfunction

endpackage

// ----- src/gda_in_if.sv -----
interface gda_in_if #(
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic [gda_pkg::MONTH_BITS-1:0]      first_month;
    logic [gda_pkg::DAY_BITS-1:0]        first_day;
    logic [gda_pkg::YEAR_BITS-1:0]       first_year;
    logic [gda_pkg::MONTH_BITS-1:0]      second_month;
    logic [gda_pkg::DAY_BITS-1:0]        second_day;
    logic [gda_pkg::YEAR_BITS-1:0]       second_year;
    logic [DAY_COUNT_BITS-1:0]           day_count;

    modport source (
        output valid, operation, first_month, first_day, first_year,
               second_month, second_day, second_year, day_count,
        input  ready
    );

    modport sink (
        input  valid, operation, first_month, first_day, first_year,
               second_month, second_day, second_year, day_count,
        output ready
    );
endinterface

// ----- src/gda_out_if.sv -----
interface gda_out_if;
    logic                                valid;
    logic                                ready;
    logic [gda_pkg::MONTH_BITS-1:0]      result_month;
    logic [gda_pkg::DAY_BITS-1:0]        result_day;
    logic [gda_pkg::YEAR_BITS-1:0]       result_year;
    logic signed [gda_pkg::DIFF_BITS-1:0] day_difference;
    logic [1:0]                          status;

    modport source (
        output valid, result_month, result_day, result_year, day_difference, status,
        input  ready
    );

    modport sink (
        input  valid, result_month, result_day, result_year, day_difference, status,
        output ready
    );
endinterface

// ----- src/gregorian_date_arithmetic.sv -----
// Gregorian date unit: add days to a date, subtract days from it, or count the
// signed days between two dates. Each transfer on the input channel yields
// exactly one transfer on the output channel, in order.
// The input channel carries the operation, two dates and a day count; the
// output channel carries the result date, the day difference and a status.
// One item is worked on at a time. Years are walked one per cycle, then,
// for add and subtract, months one per cycle (at most 11). A difference, or
// a result year out of range, ends with the year walk, and an invalid request
// walks neither. For add and subtract the years walked are about day_count /
// 365; for a difference they are the distance between the two years, up to
// about 8200. The year and month walks through one shared stepper set the
// throughput: a new item is taken the cycle after the previous result enters
// the output register, and not before. A result waits in that register while
// the receiver stalls, and the next item may be taken and worked on meanwhile;
// its result is held back until the register is free. Reset empties the
// output register and returns the controller to idle, ready for a new item.
module gregorian_date_arithmetic #(
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_out
);
    gda_pkg::t_cmd  w_cmd;
    gda_pkg::t_stat w_stat;

    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gda_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

// ----- src/gda_datapath.sv -----
module gda_datapath #(
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gda_pkg::t_cmd i_cmd,
    output gda_pkg::t_stat o_stat,
    gda_in_if.sink        i_in,
    gda_out_if.source     o_out
);
    localparam int TW = DAY_COUNT_BITS + 11;

    logic [1:0]                      r_op;
    logic [gda_pkg::MONTH_BITS-1:0]  r_m1, r_m2;
    logic [gda_pkg::DAY_BITS-1:0]    r_d1, r_d2;
    logic [gda_pkg::YEAR_BITS-1:0]   r_y1, r_y2;
    logic [DAY_COUNT_BITS-1:0]       r_cnt;
    logic [gda_pkg::CENT_BITS-1:0]   r_q1, r_q2;
    logic [gda_pkg::YC_BITS-1:0]     r_yc1, r_yc2;
    logic [gda_pkg::CENT_BITS-1:0]   r_cur_c;
    logic [gda_pkg::YC_BITS-1:0]     r_cur_yc;
    logic signed [TW-1:0]            r_t;
    logic signed [gda_pkg::DIFF_BITS-1:0] r_acc;
    logic [gda_pkg::MONTH_BITS-1:0]  r_mo;
    logic [1:0]                      r_status;

    logic                            r_out_valid;
    logic [gda_pkg::MONTH_BITS-1:0]  r_out_month;
    logic [gda_pkg::DAY_BITS-1:0]    r_out_day;
    logic [gda_pkg::YEAR_BITS-1:0]   r_out_year;
    logic signed [gda_pkg::DIFF_BITS-1:0] r_out_diff;
    logic [1:0]                      r_out_status;

    logic [gda_pkg::PROD_BITS-1:0]   w_prod1, w_prod2;
    logic                            w_leap1, w_leap2, w_bad;
    logic [gda_pkg::DOY_BITS-1:0]    w_doy1, w_doy2;
    logic                            w_cur_leap, w_dec_leap;
    logic [gda_pkg::CENT_BITS-1:0]   w_inc_c, w_dec_c;
    logic [gda_pkg::YC_BITS-1:0]     w_inc_yc, w_dec_yc;
    logic [gda_pkg::DOY_BITS-1:0]    w_ylen_cur, w_ylen_dec;
    logic                            w_at_top, w_at_bottom, w_lt, w_gt;
    logic                            w_more, w_range;
    logic [gda_pkg::DAY_BITS-1:0]    w_mlen;
    logic                            w_month_more;
    logic                            w_load;

    assign w_load = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;

    assign w_prod1 = gda_pkg::PROD_BITS'(r_y1) * gda_pkg::DIV100_MUL;
    assign w_prod2 = gda_pkg::PROD_BITS'(r_y2) * gda_pkg::DIV100_MUL;

    assign w_leap1 = gda_pkg::is_leap(r_q1, r_yc1);
    assign w_leap2 = gda_pkg::is_leap(r_q2, r_yc2);
    assign w_doy1  = gda_pkg::ordinal_day(r_m1, r_d1, w_leap1);
    assign w_doy2  = gda_pkg::ordinal_day(r_m2, r_d2, w_leap2);
    assign w_bad   = (r_op == gda_pkg::OP_NONE)
                     || !gda_pkg::date_ok(r_m1, r_d1, r_y1, w_leap1)
                     || ((r_op == gda_pkg::OP_DIFF)
                         && !gda_pkg::date_ok(r_m2, r_d2, r_y2, w_leap2));

    always_comb begin
        if (r_cur_yc == gda_pkg::YC_HIGH) begin
            w_inc_yc = '0;
            w_inc_c  = r_cur_c + 8'd1;
        end else begin
            w_inc_yc = r_cur_yc + 7'd1;
            w_inc_c  = r_cur_c;
        end
        if (r_cur_yc == '0) begin
            w_dec_yc = gda_pkg::YC_HIGH;
            w_dec_c  = r_cur_c - 8'd1;
        end else begin
            w_dec_yc = r_cur_yc - 7'd1;
            w_dec_c  = r_cur_c;
        end
    end

    assign w_cur_leap  = gda_pkg::is_leap(r_cur_c, r_cur_yc);
    assign w_dec_leap  = gda_pkg::is_leap(w_dec_c, w_dec_yc);
    assign w_ylen_cur  = gda_pkg::year_len(w_cur_leap);
    assign w_ylen_dec  = gda_pkg::year_len(w_dec_leap);
    assign w_at_top    = (r_cur_c == gda_pkg::CENT_HIGH) && (r_cur_yc == gda_pkg::YC_HIGH);
    assign w_at_bottom = (r_cur_c == gda_pkg::CENT_LOW) && (r_cur_yc == gda_pkg::YC_LOW);
    assign w_lt = (r_cur_c < r_q2) || ((r_cur_c == r_q2) && (r_cur_yc < r_yc2));
    assign w_gt = (r_cur_c > r_q2) || ((r_cur_c == r_q2) && (r_cur_yc > r_yc2));

    always_comb begin
        case (r_op)
            gda_pkg::OP_ADD: begin
                w_more  = r_t >= $signed(TW'(w_ylen_cur));
                w_range = w_more && w_at_top;
            end
            gda_pkg::OP_SUB: begin
                w_more  = r_t[TW-1];
                w_range = w_more && w_at_bottom;
            end
            gda_pkg::OP_DIFF: begin
                w_more  = w_lt || w_gt;
                w_range = 1'b0;
            end
            default: begin
                w_more  = 1'b0;
                w_range = 1'b0;
            end
        endcase
    end

    assign w_mlen       = gda_pkg::month_len(r_mo, w_cur_leap);
    assign w_month_more = r_t >= $signed(TW'(w_mlen));

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.check_bad  = w_bad;
    assign o_stat.year_done  = !w_more || w_range;
    assign o_stat.range_hit  = w_range;
    assign o_stat.is_diff    = (r_op == gda_pkg::OP_DIFF);
    assign o_stat.month_done = !w_month_more;
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op  <= i_in.operation;
            r_m1  <= i_in.first_month;
            r_d1  <= i_in.first_day;
            r_y1  <= i_in.first_year;
            r_m2  <= i_in.second_month;
            r_d2  <= i_in.second_day;
            r_y2  <= i_in.second_year;
            r_cnt <= i_in.day_count;
        end
        if (i_cmd.div) begin
            r_q1 <= w_prod1[gda_pkg::DIV100_SHIFT +: gda_pkg::CENT_BITS];
            r_q2 <= w_prod2[gda_pkg::DIV100_SHIFT +: gda_pkg::CENT_BITS];
        end
        if (i_cmd.rem) begin
            r_yc1 <= gda_pkg::YC_BITS'(r_y1 - gda_pkg::YEAR_BITS'(r_q1) * gda_pkg::CENTURY);
            r_yc2 <= gda_pkg::YC_BITS'(r_y2 - gda_pkg::YEAR_BITS'(r_q2) * gda_pkg::CENTURY);
        end
        if (i_cmd.check) begin
            r_status <= w_bad ? gda_pkg::ST_INVALID : gda_pkg::ST_OK;
            r_cur_c  <= r_q1;
            r_cur_yc <= r_yc1;
            r_mo     <= 4'd1;
            r_acc    <= $signed(gda_pkg::DIFF_BITS'(w_doy2))
                        - $signed(gda_pkg::DIFF_BITS'(w_doy1));
            if (r_op == gda_pkg::OP_SUB) begin
                r_t <= $signed(TW'(w_doy1)) - $signed(TW'(r_cnt));
            end else begin
                r_t <= $signed(TW'(w_doy1)) + $signed(TW'(r_cnt));
            end
        end
        if (i_cmd.year_step) begin
            if (w_range) begin
                r_status <= gda_pkg::ST_RANGE;
            end else if (w_more) begin
                case (r_op)
                    gda_pkg::OP_ADD: begin
                        r_t      <= r_t - $signed(TW'(w_ylen_cur));
                        r_cur_c  <= w_inc_c;
                        r_cur_yc <= w_inc_yc;
                    end
                    gda_pkg::OP_SUB: begin
                        r_t      <= r_t + $signed(TW'(w_ylen_dec));
                        r_cur_c  <= w_dec_c;
                        r_cur_yc <= w_dec_yc;
                    end
                    default: begin
                        if (w_lt) begin
                            r_acc    <= r_acc + $signed(gda_pkg::DIFF_BITS'(w_ylen_cur));
                            r_cur_c  <= w_inc_c;
                            r_cur_yc <= w_inc_yc;
                        end else begin
                            r_acc    <= r_acc - $signed(gda_pkg::DIFF_BITS'(w_ylen_dec));
                            r_cur_c  <= w_dec_c;
                            r_cur_yc <= w_dec_yc;
                        end
                    end
                endcase
            end
        end
        if (i_cmd.month_step && w_month_more) begin
            r_t  <= r_t - $signed(TW'(w_mlen));
            r_mo <= r_mo + 4'd1;
        end
        if (i_cmd.publish) begin
            r_out_status <= r_status;
            if ((r_status == gda_pkg::ST_OK) && (r_op == gda_pkg::OP_DIFF)) begin
                r_out_month <= '0;
                r_out_day   <= '0;
                r_out_year  <= '0;
                r_out_diff  <= r_acc;
            end else if (r_status == gda_pkg::ST_OK) begin
                r_out_month <= r_mo;
                r_out_day   <= r_t[gda_pkg::DAY_BITS-1:0] + 5'd1;
                r_out_year  <= gda_pkg::YEAR_BITS'(r_cur_c) * gda_pkg::CENTURY
                               + gda_pkg::YEAR_BITS'(r_cur_yc);
                r_out_diff  <= '0;
            end else begin
                r_out_month <= '0;
                r_out_day   <= '0;
                r_out_year  <= '0;
                r_out_diff  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_month   = r_out_month;
    assign o_out.result_day     = r_out_day;
    assign o_out.result_year    = r_out_year;
    assign o_out.day_difference = r_out_diff;
    assign o_out.status         = r_out_status;
endmodule

// ----- src/gda_ctrl.sv -----
module gda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gda_pkg::t_stat i_stat,
    output gda_pkg::t_cmd  o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_REM   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_YEAR  = 7'b0010000,
        S_MONTH = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_REM;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.check_bad ? S_DONE : S_YEAR;
            end
            S_YEAR: begin
                o_cmd.year_step = 1'b1;
                if (i_stat.year_done) begin
                    n_state = (i_stat.range_hit || i_stat.is_diff) ? S_DONE : S_MONTH;
                end
            end
            S_MONTH: begin
                o_cmd.month_step = 1'b1;
                if (i_stat.month_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gda_pkg::*;

    localparam int  DCB        = DAY_COUNT_BITS_DEF;
    localparam int  LIMIT      = 4_000_000;
    localparam int  DRAIN      = 8400;
    localparam int  RANDOM_NUM = 75;

    typedef struct packed {
        logic [1:0]            op;
        logic [MONTH_BITS-1:0] first_month;
        logic [DAY_BITS-1:0]   first_day;
        logic [YEAR_BITS-1:0]  first_year;
        logic [MONTH_BITS-1:0] second_month;
        logic [DAY_BITS-1:0]   second_day;
        logic [YEAR_BITS-1:0]  second_year;
        logic [DCB-1:0]        count;
    } date_request_t;

    typedef struct packed {
        logic [MONTH_BITS-1:0]       month;
        logic [DAY_BITS-1:0]         day;
        logic [YEAR_BITS-1:0]        year;
        logic signed [DIFF_BITS-1:0] diff;
        logic [1:0]                  status;
    } date_answer_t;

    class date_book;
        date_answer_t expected_answers[$];
        int           fault_count;

        function new();
            fault_count = 0;
        endfunction

        static function bit leap_year(longint unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int days_in(longint unsigned m, longint unsigned y);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function bit date_valid(longint unsigned m, longint unsigned d,
                                       longint unsigned y);
            if (y < YEAR_LOW || y > YEAR_HIGH || m < 1 || m > 12) return 0;
            return d >= 1 && d <= days_in(m, y);
        endfunction

        // Days counted from a fixed epoch, with the year starting in March.
        static function longint unsigned serial_of(longint unsigned m,
                                                   longint unsigned d,
                                                   longint unsigned y);
            longint unsigned ya, era, yoe, mp, doy, doe;
            ya  = (m <= 2) ? y - 1 : y;
            era = ya / 400;
            yoe = ya - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe;
        endfunction

        static function void date_of(longint unsigned z, output longint unsigned m,
                                     output longint unsigned d,
                                     output longint unsigned y);
            longint unsigned era, doe, yoe, doy, mp;
            era = z / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = (mp < 10) ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        endfunction

        function date_answer_t predict_date_op(date_request_t r);
            date_answer_t    a;
            longint unsigned z1, z, lo, hi, m, d, y;
            a = '0;
            if (r.op == OP_NONE
                || !date_valid(r.first_month, r.first_day, r.first_year)
                || (r.op == OP_DIFF
                    && !date_valid(r.second_month, r.second_day, r.second_year))) begin
                a.status = ST_INVALID;
                return a;
            end
            z1 = serial_of(r.first_month, r.first_day, r.first_year);
            if (r.op == OP_DIFF) begin
                a.diff = DIFF_BITS'(serial_of(r.second_month, r.second_day,
                                              r.second_year) - z1);
                return a;
            end
            lo = serial_of(1, 1, YEAR_LOW);
            hi = serial_of(12, 31, YEAR_HIGH);
            if (r.op == OP_ADD) begin
                z = z1 + r.count;
                if (z > hi) begin
                    a.status = ST_RANGE;
                    return a;
                end
            end else begin
                if (r.count > z1 - lo) begin
                    a.status = ST_RANGE;
                    return a;
                end
                z = z1 - r.count;
            end
            date_of(z, m, d, y);
            a.month = MONTH_BITS'(m);
            a.day   = DAY_BITS'(d);
            a.year  = YEAR_BITS'(y);
            return a;
        endfunction

        function void note_request(date_request_t r);
            expected_answers.push_back(predict_date_op(r));
        endfunction

        function void check_answer(date_answer_t got);
            date_answer_t exp_a;
            if (expected_answers.size() == 0) begin
                $display("%0t: result transfer with none pending, month %0d day %0d "
                         , $time, got.month, got.day,
                         "year %0d diff %0d status %0d", got.year, got.diff, got.status);
                fault_count++;
                return;
            end
            exp_a = expected_answers.pop_front();
            if (got.month !== exp_a.month) begin
                $display("%0t: result_month expected %0d actual %0d",
                         $time, exp_a.month, got.month);
                fault_count++;
            end
            if (got.day !== exp_a.day) begin
                $display("%0t: result_day expected %0d actual %0d",
                         $time, exp_a.day, got.day);
                fault_count++;
            end
            if (got.year !== exp_a.year) begin
                $display("%0t: result_year expected %0d actual %0d",
                         $time, exp_a.year, got.year);
                fault_count++;
            end
            if (got.diff !== exp_a.diff) begin
                $display("%0t: day_difference expected %0d actual %0d",
                         $time, exp_a.diff, got.diff);
                fault_count++;
            end
            if (got.status !== exp_a.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_a.status, got.status);
                fault_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gda_in_if #(.DAY_COUNT_BITS(DCB)) in_ch();
    gda_out_if                        out_ch();

    gregorian_date_arithmetic #(.DAY_COUNT_BITS(DCB)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    date_book      book;
    date_request_t requests[$];
    int            cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("** gregorian_date_arithmetic: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        date_answer_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.month  = out_ch.result_month;
            got.day    = out_ch.result_day;
            got.year   = out_ch.result_year;
            got.diff   = out_ch.day_difference;
            got.status = out_ch.status;
            book.check_answer(got);
        end
    end

    // The receiver switches between always ready, random, mostly stalled and
    // fully stalled stretches.
    initial begin
        int mode;
        int span;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = 1'($urandom_range(0, 1));
                    2:       out_ch.ready = ($urandom_range(0, 7) == 0);
                    default: out_ch.ready = 1'b0;
                endcase
            end
        end
    end

    function automatic date_request_t make_req(logic [1:0] op, int m1, int d1, int y1,
                                               int m2, int d2, int y2, int cnt);
        date_request_t r;
        r.op           = op;
        r.first_month  = MONTH_BITS'(m1);
        r.first_day    = DAY_BITS'(d1);
        r.first_year   = YEAR_BITS'(y1);
        r.second_month = MONTH_BITS'(m2);
        r.second_day   = DAY_BITS'(d2);
        r.second_year  = YEAR_BITS'(y2);
        r.count        = DCB'(cnt);
        return r;
    endfunction

    function automatic void pick_date(int ylo, int yhi, output int m, output int d,
                                      output int y);
        y = $urandom_range(ylo, yhi);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, date_book::days_in(m, y));
    endfunction

    function automatic date_request_t random_request();
        date_request_t r;
        int            kind;
        int            m, d, y, y2;
        kind = $urandom_range(0, 99);
        r.op           = 2'($urandom_range(0, 3));
        r.first_month  = MONTH_BITS'($urandom);
        r.first_day    = DAY_BITS'($urandom);
        r.first_year   = YEAR_BITS'($urandom);
        r.second_month = MONTH_BITS'($urandom);
        r.second_day   = DAY_BITS'($urandom);
        r.second_year  = YEAR_BITS'($urandom);
        r.count        = DCB'($urandom);
        if (kind >= 90) return r;
        if (kind < 80) begin
            pick_date(YEAR_LOW, YEAR_HIGH, m, d, y);
            r.op = 2'($urandom_range(0, 2));
        end else begin
            if ($urandom_range(0, 1)) pick_date(YEAR_LOW, YEAR_LOW + 4, m, d, y);
            else pick_date(YEAR_HIGH - 4, YEAR_HIGH, m, d, y);
            r.op = 2'($urandom_range(0, 1));
        end
        r.first_month = MONTH_BITS'(m);
        r.first_day   = DAY_BITS'(d);
        r.first_year  = YEAR_BITS'(y);
        case ($urandom_range(0, 3))
            0:       r.count = DCB'($urandom_range(0, 31));
            1:       r.count = DCB'($urandom_range(0, 400));
            2:       r.count = DCB'($urandom_range(0, 3000));
            default: r.count = DCB'($urandom);
        endcase
        if (r.op == OP_DIFF) begin
            if ($urandom_range(0, 24) == 0) begin
                pick_date(YEAR_LOW, YEAR_HIGH, m, d, y2);
            end else begin
                y2 = y + $urandom_range(0, 30) - 15;
                if (y2 < YEAR_LOW) y2 = YEAR_LOW;
                if (y2 > YEAR_HIGH) y2 = YEAR_HIGH;
                pick_date(y2, y2, m, d, y2);
            end
            r.second_month = MONTH_BITS'(m);
            r.second_day   = DAY_BITS'(d);
            r.second_year  = YEAR_BITS'(y2);
        end
        return r;
    endfunction

    task automatic send_request(date_request_t r);
        @(negedge i_clk);
        in_ch.valid        = 1'b1;
        in_ch.operation    = r.op;
        in_ch.first_month  = r.first_month;
        in_ch.first_day    = r.first_day;
        in_ch.first_year   = r.first_year;
        in_ch.second_month = r.second_month;
        in_ch.second_day   = r.second_day;
        in_ch.second_year  = r.second_year;
        in_ch.day_count    = r.count;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        book.note_request(r);
    endtask

    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
    endtask

    initial begin
        int idx;
        int burst;
        book               = new();
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.operation    = OP_ADD;
        in_ch.first_month  = '0;
        in_ch.first_day    = '0;
        in_ch.first_year   = '0;
        in_ch.second_month = '0;
        in_ch.second_day   = '0;
        in_ch.second_year  = '0;
        in_ch.day_count    = '0;

        requests.push_back(make_req(OP_ADD,  2, 29, 2024, 0, 0, 0, 0));
        requests.push_back(make_req(OP_ADD,  1, 1, 1801, 0, 0, 0, 65535));
        requests.push_back(make_req(OP_ADD, 12, 31, 9999, 0, 0, 0, 1));
        requests.push_back(make_req(OP_ADD, 12, 30, 9999, 0, 0, 0, 1));
        requests.push_back(make_req(OP_SUB,  1, 1, 1801, 0, 0, 0, 1));
        requests.push_back(make_req(OP_SUB,  1, 2, 1801, 0, 0, 0, 1));
        requests.push_back(make_req(OP_SUB, 12, 31, 9999, 0, 0, 0, 65535));
        requests.push_back(make_req(OP_DIFF, 1, 1, 1801, 12, 31, 9999, 0));
        requests.push_back(make_req(OP_DIFF, 12, 31, 9999, 1, 1, 1801, 0));
        requests.push_back(make_req(OP_DIFF, 2, 29, 2000, 2, 29, 2000, 0));
        requests.push_back(make_req(OP_NONE, 6, 15, 2020, 6, 15, 2020, 10));
        requests.push_back(make_req(OP_ADD,  0, 10, 2020, 0, 0, 0, 5));
        requests.push_back(make_req(OP_SUB, 13, 10, 2020, 0, 0, 0, 5));
        requests.push_back(make_req(OP_DIFF, 15, 10, 2020, 1, 1, 2021, 0));
        requests.push_back(make_req(OP_ADD,  5, 0, 2020, 0, 0, 0, 5));
        requests.push_back(make_req(OP_ADD,  4, 31, 2020, 0, 0, 0, 5));
        requests.push_back(make_req(OP_ADD,  2, 29, 1900, 0, 0, 0, 5));
        requests.push_back(make_req(OP_ADD,  2, 29, 2000, 0, 0, 0, 365));
        requests.push_back(make_req(OP_ADD, 12, 31, 1800, 0, 0, 0, 1));
        requests.push_back(make_req(OP_SUB,  1, 1, 10000, 0, 0, 0, 1));
        requests.push_back(make_req(OP_NONE, 15, 31, 16383, 15, 31, 16383, 65535));
        requests.push_back(make_req(OP_ADD,  0, 0, 0, 0, 0, 0, 0));
        requests.push_back(make_req(OP_DIFF, 3, 1, 2001, 2, 29, 2001, 0));
        requests.push_back(make_req(OP_ADD,  2, 28, 2100, 0, 0, 0, 1));
        requests.push_back(make_req(OP_SUB,  3, 1, 2000, 0, 0, 0, 1));
        repeat (RANDOM_NUM) requests.push_back(random_request());

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idx = 0;
        while (idx < requests.size()) begin
            burst = ($urandom_range(0, 5) == 0) ? 20 : $urandom_range(1, 8);
            while (burst > 0 && idx < requests.size()) begin
                send_request(requests[idx]);
                idx++;
                burst--;
            end
            hold_off($urandom_range(0, 1) ? 1 + $urandom_range(0, 2)
                                          : $urandom_range(0, 12));
        end
        hold_off(1);

        while (book.expected_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (book.fault_count == 0) begin
            $display("** gregorian_date_arithmetic: PASSED **");
        end else begin
            $display("** gregorian_date_arithmetic: FAILED **");
        end
        $finish;
    end

endmodule
